>>> design/pwrmv_pkg.sv
package pwrmv_pkg;

    localparam int NUM_PIXELS = 262144;
    localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    localparam int INDEX_W = 18;
    localparam int VAL_W   = 8;
    localparam int WGT_W   = 16;
    localparam int MEAN_W  = 24;
    localparam int WT_W    = 32;
    localparam int DEV_W   = 56;
    localparam int CNT_W   = 16;
    localparam int VAR_W   = 32;
    localparam int CFG_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int DW_W    = MEAN_W + WGT_W;
    localparam int TERM_W  = DW_W + MEAN_W - 24;
    localparam int PLO_W   = 32 + MEAN_W;
    localparam int PHI_W   = (DW_W - 32) + MEAN_W;

    localparam int DIV_W      = 32;
    localparam int DIV_STAGES = DIV_W;

    localparam int STORE_W = MEAN_W + WT_W + DEV_W + CNT_W;

    typedef enum logic [0:0] {
        CFG_VARIANCE_ENABLE,
        CFG_TARGET_SAMPLES
    } cfg_reg_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [WT_W-1:0]   wt;
        logic [DEV_W-1:0]  dev;
        logic [CNT_W-1:0]  cnt;
    } store_t;

    typedef struct packed {
        logic              valid;
        logic              in_range;
        logic [ADDR_W-1:0] idx;
        logic              first;
        logic              last;
        logic              mask;
        logic [VAL_W-1:0]  x;
        logic [WGT_W-1:0]  w;
    } in_t;

    typedef struct packed {
        logic              valid;
        logic              in_range;
        logic              wen;
        logic              upd;
        logic              first_smp;
        logic [ADDR_W-1:0] idx;
        logic              last;
        logic              done;
        logic [MEAN_W-1:0] x16;
        logic [WGT_W-1:0]  w;
        logic [MEAN_W-1:0] mean;
        logic [WT_W-1:0]   wt;
        logic [DEV_W-1:0]  dev;
        logic [CNT_W-1:0]  cnt;
        logic              dneg;
        logic [MEAN_W-1:0] dmag;
        logic [DW_W-1:0]   dw;
        logic [MEAN_W-1:0] emag;
        logic              acc_s;
        logic [PLO_W-1:0]  prod_lo;
        logic [PHI_W-1:0]  prod_hi;
        logic [TERM_W-1:0] term;
    } pipe_t;

endpackage

>>> design/pixel_weighted_running_mean_variance.sv
// Throughput: one word per cycle unless out_stall holds back a result; a word whose pixel is still
// in flight before its write-back (the read-modify-write of the pixel memory) waits until it is written.
// Reset: a clearing pass zeroes the pixel memory, one pixel a cycle, with in_stall high;
// configuration writes are taken throughout.
module pixel_weighted_running_mean_variance import pwrmv_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [INDEX_W-1:0] pixel_index,
    input  logic [VAL_W-1:0]   pixel_value,
    input  logic [WGT_W-1:0]   pixel_weight,
    input  logic               pixel_mask,
    input  logic               first_of_frame,
    input  logic               last_of_frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [MEAN_W-1:0]  mean_value,
    output logic [VAR_W-1:0]   variance_value,
    output logic [WT_W-1:0]    weight_total,
    output logic [CNT_W-1:0]   sample_count,
    output logic               frames_done,
    output logic               frame_end
);

    logic              variance_enable_reg;
    logic [CNT_W-1:0]  target_samples_reg;
    logic              done_flag_reg;
    logic              clearing_reg;
    logic [CNT_W-1:0]  frame_min_reg;
    logic              init_busy_reg;
    logic [ADDR_W-1:0] init_addr_reg;

    in_t   a_reg;
    in_t   a_next;
    pipe_t b_reg;
    pipe_t b_next;
    pipe_t m_in;
    pipe_t mside_reg [DIV_STAGES];
    pipe_t d_reg;
    pipe_t d_next;
    pipe_t e_reg;
    pipe_t e_next;
    pipe_t f_reg;
    pipe_t f_next;
    pipe_t g_reg;
    pipe_t g_next;
    pipe_t vside_reg [DIV_STAGES];

    logic              out_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [VAR_W-1:0]  var_next;
    logic [WT_W-1:0]   wt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic              end_reg;

    logic              adv;
    logic              hazard;
    logic              accept;
    logic [ADDR_W-1:0] in_addr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    store_t             ram_wdata;
    logic [STORE_W-1:0] ram_rdata;

    store_t            rd;
    store_t            cur;
    logic              clr;
    logic              upd;
    logic [WT_W:0]     wsum;
    logic [WT_W-1:0]   wnew;
    logic [MEAN_W-1:0] x16;
    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  min_base;
    logic [CNT_W-1:0]  min_new;
    logic              done;

    logic [DIV_W-1:0]  mquot;
    logic              mover;
    logic [DIV_W-1:0]  vquot;
    logic              vover;
    logic [MEAN_W-1:0] mnew;
    logic              eneg;
    logic [2*DIV_W-1:0] full;
    logic [DEV_W:0]    ssum;

    assign adv     = !out_valid_reg || !out_stall;
    assign in_addr = ADDR_W'(pixel_index);
    assign in_stall = init_busy_reg || !adv || hazard;
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        hazard = (a_reg.valid && a_reg.idx == in_addr)
              || (b_reg.valid && b_reg.idx == in_addr)
              || (d_reg.valid && d_reg.idx == in_addr)
              || (e_reg.valid && e_reg.idx == in_addr)
              || (f_reg.valid && f_reg.idx == in_addr)
              || (g_reg.valid && g_reg.idx == in_addr);
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (mside_reg[k].valid && mside_reg[k].idx == in_addr)
            begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variance_enable_reg <= 1'b0;
            target_samples_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_VARIANCE_ENABLE: variance_enable_reg <= cfg_data[0];
                CFG_TARGET_SAMPLES:  target_samples_reg  <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end
        else if (init_busy_reg)
        begin
            if (init_addr_reg == ADDR_W'(NUM_PIXELS - 1))
            begin
                init_busy_reg <= 1'b0;
            end
            else
            begin
                init_addr_reg <= init_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        a_next.valid    = accept;
        a_next.in_range = (32'(pixel_index) < 32'(NUM_PIXELS));
        a_next.idx      = in_addr;
        a_next.first    = first_of_frame;
        a_next.last     = last_of_frame;
        a_next.mask     = pixel_mask;
        a_next.x        = pixel_value;
        a_next.w        = pixel_weight;
    end

    // Clear, weight, count and frame bookkeeping and the deviation from the stored mean, in word order
    always_comb
    begin
        rd       = store_t'(ram_rdata);
        clr      = a_reg.first ? done_flag_reg : clearing_reg;
        cur      = clr ? '0 : rd;
        upd      = a_reg.in_range && a_reg.mask && (a_reg.w != '0);
        wsum     = {1'b0, cur.wt} + (WT_W+1)'(a_reg.w);
        wnew     = wsum[WT_W] ? '1 : wsum[WT_W-1:0];
        x16      = {a_reg.x, FRAC_W'(0)};
        cnt_new  = (upd && cur.cnt != '1) ? cur.cnt + CNT_W'(1) : cur.cnt;
        min_base = a_reg.first ? '1 : frame_min_reg;
        min_new  = (a_reg.in_range && cnt_new < min_base) ? cnt_new : min_base;
        done     = a_reg.last && (target_samples_reg != '0) && (min_new >= target_samples_reg);

        b_next           = '0;
        b_next.valid     = a_reg.valid;
        b_next.in_range  = a_reg.in_range;
        b_next.wen       = a_reg.in_range && (clr || upd);
        b_next.upd       = upd;
        b_next.first_smp = (cur.cnt == '0);
        b_next.idx       = a_reg.idx;
        b_next.last      = a_reg.last;
        b_next.done      = done;
        b_next.x16       = x16;
        b_next.w         = a_reg.w;
        b_next.mean      = a_reg.in_range ? cur.mean : '0;
        b_next.wt        = a_reg.in_range ? (upd ? wnew : cur.wt) : '0;
        b_next.dev       = a_reg.in_range ? cur.dev : '0;
        b_next.cnt       = a_reg.in_range ? cnt_new : '0;
        b_next.dneg      = (x16 < cur.mean);
        b_next.dmag      = (x16 < cur.mean) ? cur.mean - x16 : x16 - cur.mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_flag_reg <= 1'b1;
            clearing_reg  <= 1'b0;
            frame_min_reg <= '1;
        end
        else if (adv && a_reg.valid)
        begin
            frame_min_reg <= min_new;
            clearing_reg  <= a_reg.last ? 1'b0 : clr;
            done_flag_reg <= done ? 1'b1 : (a_reg.first ? 1'b0 : done_flag_reg);
        end
    end

    always_comb
    begin
        m_in    = b_reg;
        m_in.dw = DW_W'(b_reg.dmag) * DW_W'(b_reg.w);
    end

    pwrmv_div u_mean_div (
        .clk  (clk),
        .en   (adv),
        .num  ((2*DIV_W)'(m_in.dw)),
        .den  (m_in.wt),
        .quot (mquot),
        .over (mover)
    );

    always_comb
    begin
        if (!mside_reg[DIV_STAGES-1].upd)
        begin
            mnew = mside_reg[DIV_STAGES-1].mean;
        end
        else if (mside_reg[DIV_STAGES-1].first_smp)
        begin
            mnew = mside_reg[DIV_STAGES-1].x16;
        end
        else if (mside_reg[DIV_STAGES-1].dneg)
        begin
            mnew = mside_reg[DIV_STAGES-1].mean - mquot[MEAN_W-1:0];
        end
        else
        begin
            mnew = mside_reg[DIV_STAGES-1].mean + mquot[MEAN_W-1:0];
        end
        eneg        = (mside_reg[DIV_STAGES-1].x16 < mnew);
        d_next      = mside_reg[DIV_STAGES-1];
        d_next.mean = mnew;
        d_next.emag = eneg ? mnew - mside_reg[DIV_STAGES-1].x16
                           : mside_reg[DIV_STAGES-1].x16 - mnew;
        // drop the term where the two deviations have opposite signs
        d_next.acc_s = mside_reg[DIV_STAGES-1].upd && !mside_reg[DIV_STAGES-1].first_smp
                    && variance_enable_reg
                    && !(d_next.emag != '0 && mside_reg[DIV_STAGES-1].dmag != '0
                         && eneg != mside_reg[DIV_STAGES-1].dneg);
    end

    always_comb
    begin
        e_next         = d_reg;
        e_next.prod_lo = PLO_W'(d_reg.dw[31:0]) * PLO_W'(d_reg.emag);
        e_next.prod_hi = PHI_W'(d_reg.dw[DW_W-1:32]) * PHI_W'(d_reg.emag);
    end

    always_comb
    begin
        full        = {e_reg.prod_hi, 32'b0} + (2*DIV_W)'(e_reg.prod_lo);
        f_next      = e_reg;
        f_next.term = full[2*DIV_W-1:24];
    end

    always_comb
    begin
        ssum   = {1'b0, f_reg.dev} + (DEV_W+1)'(f_reg.term);
        g_next = f_reg;
        if (f_reg.acc_s)
        begin
            g_next.dev = ssum[DEV_W] ? '1 : ssum[DEV_W-1:0];
        end
    end

    assign ram_we    = init_busy_reg || (adv && g_reg.valid && g_reg.wen);
    assign ram_waddr = init_busy_reg ? init_addr_reg : g_reg.idx;
    always_comb
    begin
        ram_wdata.mean = init_busy_reg ? '0 : g_reg.mean;
        ram_wdata.wt   = init_busy_reg ? '0 : g_reg.wt;
        ram_wdata.dev  = init_busy_reg ? '0 : g_reg.dev;
        ram_wdata.cnt  = init_busy_reg ? '0 : g_reg.cnt;
    end

    pwrmv_ram #(
        .WIDTH (STORE_W),
        .DEPTH (NUM_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (STORE_W'(ram_wdata)),
        .re    (adv),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    pwrmv_div u_var_div (
        .clk  (clk),
        .en   (adv),
        .num  ({g_reg.dev, 8'b0}),
        .den  (g_reg.wt),
        .quot (vquot),
        .over (vover)
    );

    always_comb
    begin
        if (variance_enable_reg && vside_reg[DIV_STAGES-1].wt != '0)
        begin
            var_next = vover ? '1 : vquot;
        end
        else
        begin
            var_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg.valid   <= 1'b0;
            b_reg.valid   <= 1'b0;
            d_reg.valid   <= 1'b0;
            e_reg.valid   <= 1'b0;
            f_reg.valid   <= 1'b0;
            g_reg.valid   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                mside_reg[k].valid <= 1'b0;
                vside_reg[k].valid <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            mside_reg[0] <= m_in;
            vside_reg[0] <= g_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                mside_reg[k] <= mside_reg[k-1];
                vside_reg[k] <= vside_reg[k-1];
            end
            d_reg         <= d_next;
            e_reg         <= e_next;
            f_reg         <= f_next;
            g_reg         <= g_next;
            out_valid_reg <= vside_reg[DIV_STAGES-1].valid;
            mean_reg      <= vside_reg[DIV_STAGES-1].mean;
            var_reg       <= var_next;
            wt_reg        <= vside_reg[DIV_STAGES-1].wt;
            cnt_reg       <= vside_reg[DIV_STAGES-1].cnt;
            done_reg      <= vside_reg[DIV_STAGES-1].done;
            end_reg       <= vside_reg[DIV_STAGES-1].last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mean_value     = mean_reg;
    assign variance_value = var_reg;
    assign weight_total   = wt_reg;
    assign sample_count   = cnt_reg;
    assign frames_done    = done_reg;
    assign frame_end      = end_reg;

`ifndef ASSERT_OFF
    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !init_busy_reg && a_reg.valid) |-> (a_reg.idx != g_reg.idx))
        else $error("pixel read while its write-back is pending");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy_reg |-> (!a_reg.valid && !out_valid_reg && in_stall))
        else $error("word in flight during clearing pass");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frames_done || frame_end))
        else $error("frames_done without frame_end");

    a_no_update_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (b_reg.valid && !b_reg.in_range) |-> (!b_reg.wen && b_reg.wt == '0))
        else $error("out-of-range pixel touches the stores");
`endif

endmodule

>>> design/pwrmv_ram.sv
module pwrmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pwrmv_div.sv
module pwrmv_div import pwrmv_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic [2*DIV_W-1:0] num,
    input  logic [DIV_W-1:0]   den,
    output logic [DIV_W-1:0]   quot,
    output logic               over
);

    logic [DIV_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0] lo_reg   [DIV_STAGES];
    logic [DIV_W-1:0] q_reg    [DIV_STAGES];
    logic [DIV_W-1:0] den_reg  [DIV_STAGES];
    logic             over_reg [DIV_STAGES];

    logic [DIV_W-1:0] rem_in   [DIV_STAGES];
    logic [DIV_W-1:0] lo_in    [DIV_STAGES];
    logic [DIV_W-1:0] q_in     [DIV_STAGES];
    logic [DIV_W-1:0] den_in   [DIV_STAGES];
    logic             over_in  [DIV_STAGES];

    logic [DIV_W:0]   trial    [DIV_STAGES];
    logic             ge       [DIV_STAGES];
    logic [DIV_W-1:0] rem_next [DIV_STAGES];

    always_comb
    begin
        rem_in[0]  = num[2*DIV_W-1:DIV_W];
        lo_in[0]   = num[DIV_W-1:0];
        q_in[0]    = '0;
        den_in[0]  = den;
        over_in[0] = (num[2*DIV_W-1:DIV_W] >= den);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            lo_in[k]   = lo_reg[k-1];
            q_in[k]    = q_reg[k-1];
            den_in[k]  = den_reg[k-1];
            over_in[k] = over_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial[k]    = {rem_in[k], lo_in[k][DIV_W-1]};
            ge[k]       = (trial[k] >= {1'b0, den_in[k]});
            rem_next[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, den_in[k]}) : trial[k][DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                lo_reg[k]   <= {lo_in[k][DIV_W-2:0], 1'b0};
                q_reg[k]    <= {q_in[k][DIV_W-2:0], ge[k]};
                den_reg[k]  <= den_in[k];
                over_reg[k] <= over_in[k];
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];
    assign over = over_reg[DIV_STAGES-1];

endmodule

>>> tb/pixel_stats_checker.sv
module pixel_stats_checker import pwrmv_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [INDEX_W-1:0] pixel_index,
    input  logic [VAL_W-1:0]   pixel_value,
    input  logic [WGT_W-1:0]   pixel_weight,
    input  logic               pixel_mask,
    input  logic               first_of_frame,
    input  logic               last_of_frame,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [MEAN_W-1:0]  mean_value,
    input  logic [VAR_W-1:0]   variance_value,
    input  logic [WT_W-1:0]    weight_total,
    input  logic [CNT_W-1:0]   sample_count,
    input  logic               frames_done,
    input  logic               frame_end,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [MEAN_W-1:0] mean;
        bit [VAR_W-1:0]  var_q;
        bit [WT_W-1:0]   wt;
        bit [CNT_W-1:0]  cnt;
        bit              done;
        bit              fend;
    } pixel_stats_t;

    localparam bit [DEV_W-1:0] DEV_SAT = {DEV_W{1'b1}};

    bit [MEAN_W-1:0] mean_mem [NUM_PIXELS];
    bit [WT_W-1:0]   wt_mem   [NUM_PIXELS];
    bit [DEV_W-1:0]  dev_mem  [NUM_PIXELS];
    bit [CNT_W-1:0]  cnt_mem  [NUM_PIXELS];
    bit              done_pending;
    bit              clearing;
    bit [CNT_W-1:0]  min_count;
    bit              var_on;
    bit [CNT_W-1:0]  target;

    pixel_stats_t expected_stats [$];

    assign pending = expected_stats.size();

    function automatic void fold_sample(bit [ADDR_W-1:0] p, bit [7:0] x, bit [15:0] w);
        bit [31:0] x16;
        bit [31:0] m;
        bit [32:0] wsum;
        bit [31:0] wnew;
        bit        dneg;
        bit        eneg;
        bit [63:0] dmag;
        bit [63:0] emag;
        bit [63:0] dw;
        bit [63:0] inc;
        bit [31:0] mnew;
        bit [63:0] term;
        bit [63:0] s;
        x16  = {8'd0, x, 16'd0};
        m    = {8'd0, mean_mem[p]};
        wsum = {1'b0, wt_mem[p]} + 33'(w);
        wnew = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        if (cnt_mem[p] == 0)
            mean_mem[p] = x16[23:0];
        else
        begin
            dneg = x16 < m;
            dmag = dneg ? 64'(m - x16) : 64'(x16 - m);
            dw   = dmag * 64'(w);
            inc  = dw / 64'(wnew);
            mnew = dneg ? m - inc[31:0] : m + inc[31:0];
            mean_mem[p] = mnew[23:0];
            mnew = {8'd0, mnew[23:0]};
            if (var_on)
            begin
                eneg = x16 < mnew;
                emag = eneg ? 64'(mnew - x16) : 64'(x16 - mnew);
                if (!(emag != 0 && dmag != 0 && eneg != dneg))
                begin
                    term = (dw * emag) >> 24;
                    s    = 64'(dev_mem[p]);
                    dev_mem[p] = (term > 64'(DEV_SAT) - s) ? DEV_SAT : DEV_W'(s + term);
                end
            end
        end
        wt_mem[p] = wnew;
        if (cnt_mem[p] != 16'hFFFF)
            cnt_mem[p] = cnt_mem[p] + 1'b1;
    endfunction

    function automatic pixel_stats_t predict_pixel(bit [17:0] p, bit [7:0] x, bit [15:0] w,
                                                   bit mask, bit first, bit last);
        pixel_stats_t r;
        bit [63:0]    q;
        r = '{default: 0};
        if (first)
        begin
            min_count    = 16'hFFFF;
            clearing     = done_pending;
            done_pending = 0;
        end
        if (int'(p) < NUM_PIXELS)
        begin
            if (clearing)
            begin
                mean_mem[p] = 0;
                wt_mem[p]   = 0;
                dev_mem[p]  = 0;
                cnt_mem[p]  = 0;
            end
            if (mask && w != 0)
                fold_sample(ADDR_W'(p), x, w);
            r.mean = mean_mem[p];
            r.wt   = wt_mem[p];
            r.cnt  = cnt_mem[p];
            if (var_on && r.wt != 0)
            begin
                q = {dev_mem[p], 8'd0} / 64'(r.wt);
                r.var_q = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            if (cnt_mem[p] < min_count)
                min_count = cnt_mem[p];
        end
        if (last)
        begin
            if (target != 0 && min_count >= target)
            begin
                r.done       = 1;
                done_pending = 1;
            end
            clearing = 0;
        end
        r.fend = last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_stats_t e;
        if (!rst_n)
        begin
            done_pending = 1;
            clearing     = 0;
            min_count    = 16'hFFFF;
            var_on       = 0;
            target       = 0;
            fail_count   = 0;
            expected_stats.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_VARIANCE_ENABLE)
                    var_on = cfg_data[0];
                else if (cfg_index == CFG_TARGET_SAMPLES)
                    target = cfg_data;
            end
            if (in_valid && !in_stall)
                expected_stats.push_back(predict_pixel(pixel_index, pixel_value, pixel_weight,
                                                       pixel_mask, first_of_frame,
                                                       last_of_frame));
            if (out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: unexpected result word", $realtime);
                end
                else
                begin
                    e = expected_stats.pop_front();
                    if (mean_value !== e.mean || variance_value !== e.var_q ||
                        weight_total !== e.wt || sample_count !== e.cnt ||
                        frames_done !== e.done || frame_end !== e.fend)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%t: mismatch exp mean %h var %h wt %h cnt %h done %b end %b",
                                     $realtime, e.mean, e.var_q, e.wt, e.cnt, e.done, e.fend);
                            $display("%t: mismatch got mean %h var %h wt %h cnt %h done %b end %b",
                                     $realtime, mean_value, variance_value, weight_total,
                                     sample_count, frames_done, frame_end);
                        end
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
module tb import pwrmv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1500000;
    localparam int TAIL       = 120;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_write = 0;
    logic [0:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [INDEX_W-1:0] pixel_index = '0;
    logic [VAL_W-1:0]   pixel_value = '0;
    logic [WGT_W-1:0]   pixel_weight = '0;
    logic               pixel_mask = 0;
    logic               first_of_frame = 0;
    logic               last_of_frame = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [MEAN_W-1:0]  mean_value;
    logic [VAR_W-1:0]   variance_value;
    logic [WT_W-1:0]    weight_total;
    logic [CNT_W-1:0]   sample_count;
    logic               frames_done;
    logic               frame_end;

    int  fail_count;
    int  pending;
    bit  word_taken;
    int  idle_cycles;
    bit  smooth;
    int  stall_pct;
    bit [17:0] pool [8];

    always #5 clk = ~clk;

    pixel_weighted_running_mean_variance dut (.*);

    pixel_stats_checker checker_i (.*);

    always @(posedge clk)
    begin
        word_taken <= in_valid && !in_stall;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (smooth || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
        out_stall <= (!smooth && $urandom_range(0, 99) < stall_pct) ?
                     ($urandom_range(0, 19) != 0) : 1'b0;

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg_write = 1;
        cfg_index = idx;
        cfg_data  = val[CFG_W-1:0];
        @(negedge clk);
        cfg_write = 0;
    endtask

    task automatic send_word(bit [17:0] p, bit [7:0] x, bit [15:0] w, bit m, bit f, bit l);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 0;
            repeat (g) @(negedge clk);
        end
        pixel_index    = p;
        pixel_value    = x;
        pixel_weight   = w;
        pixel_mask     = m;
        first_of_frame = f;
        last_of_frame  = l;
        in_valid       = 1;
        do
            @(negedge clk);
        while (!word_taken);
    endtask

    task automatic drain();
        in_valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
    endtask

    function automatic bit [7:0] rand_value();
        unique case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bit [15:0] rand_weight();
        unique case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            3: return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_phase(int n_words);
        int k;
        int n;
        int sent;
        sent = 0;
        k = $urandom_range(1, 6);
        for (int i = 0; i < 8; i++)
            pool[i] = (i == 0) ? 18'd0 : (i == 1) ? 18'h3FFFF : 18'($urandom_range(0, 40));
        while (sent < n_words)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n = $urandom_range(1, k);
                for (int i = 0; i < n; i++)
                    send_word(pool[3'($urandom_range(0, k - 1))], rand_value(), rand_weight(),
                              $urandom_range(0, 9) != 0, i == 0, i == n - 1);
                sent += n;
            end
            else
            begin
                send_word(18'($urandom_range(0, 262143)), rand_value(), rand_weight(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        smooth    = 0;
        stall_pct = 30;
        repeat (8) @(negedge clk);
        rst_n = 1;
        write_reg(CFG_VARIANCE_ENABLE, 1);
        write_reg(CFG_TARGET_SAMPLES, 2);

        send_word(18'd0,       8'd0,   16'h0100, 1, 1, 0);
        send_word(18'h3FFFF,   8'd255, 16'hFFFF, 1, 0, 0);
        send_word(18'd5,       8'd77,  16'h0200, 0, 0, 0);
        send_word(18'd5,       8'd77,  16'h0000, 1, 0, 0);
        send_word(18'd5,       8'd10,  16'h0001, 1, 0, 1);
        send_word(18'd0,       8'd255, 16'h0001, 1, 1, 0);
        send_word(18'h3FFFF,   8'd0,   16'hFFFF, 1, 0, 0);
        send_word(18'd5,       8'd200, 16'h8000, 1, 0, 0);
        send_word(18'd0,       8'd255, 16'hFFFF, 1, 0, 1);
        send_word(18'd0,       8'd128, 16'h0100, 1, 1, 0);
        send_word(18'h3FFFF,   8'd128, 16'h0100, 1, 0, 0);
        send_word(18'd5,       8'd128, 16'h0100, 1, 0, 1);
        send_word(18'd0,       8'd1,   16'h0100, 1, 0, 0);
        send_word(18'd0,       8'd254, 16'h0300, 1, 1, 0);
        send_word(18'd9,       8'd33,  16'h0100, 1, 0, 1);
        drain();
        write_reg(CFG_VARIANCE_ENABLE, 0);
        send_word(18'd0,       8'd50,  16'h0100, 1, 1, 0);
        send_word(18'd9,       8'd60,  16'h0100, 1, 0, 1);
        send_word(18'd9,       8'd60,  16'h0100, 1, 0, 1);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            smooth    = (ph == 3);
            stall_pct = (ph == 1) ? 80 : 30;
            unique case (ph)
                0:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 1);
                    write_reg(CFG_TARGET_SAMPLES, 3);
                end
                1:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 0);
                    write_reg(CFG_TARGET_SAMPLES, 1);
                end
                2:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 1);
                    write_reg(CFG_TARGET_SAMPLES, 0);
                end
                3:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 1);
                    write_reg(CFG_TARGET_SAMPLES, 65535);
                end
                4:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 0);
                    write_reg(CFG_TARGET_SAMPLES, 2);
                end
                default:
                begin
                    write_reg(CFG_VARIANCE_ENABLE, 1);
                    write_reg(CFG_TARGET_SAMPLES, 4);
                end
            endcase
            random_phase(110);
            in_valid = 0;
            while (pending != 0)
                @(negedge clk);
            random_phase(110);
        end
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
